// ===== src/pvr_pkg.sv =====
// Shared types and constants for the peak and valley ratio detector.
package pvr_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned RATIO_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LEVEL     = 1'b1;

  // Register values after reset.
  localparam logic [RATIO_W-1:0]    RATIO_RESET = 8'd230;
  localparam logic [CFG_DATA_W-1:0] FLOOR_RESET = 16'd7;

  // Event codes reported with each result word.
  typedef enum logic [2:0] {
    EV_START_VALLEY = 3'd0,
    EV_PEAK         = 3'd1,
    EV_VALLEY       = 3'd2,
    EV_PEAK_CANCEL  = 3'd3,
    EV_END_VALLEY   = 3'd4,
    EV_END_NO_VALLEY = 3'd5
  } event_e;

  // Configuration registers as seen by the detection core.
  typedef struct packed {
    logic [RATIO_W-1:0]    ratio_threshold;
    logic [CFG_DATA_W-1:0] floor_level;
  } cfg_t;

endpackage

// ===== src/pvr_core.sv =====
// Detection core: series state and the per-sample peak and valley decision.
module pvr_core #(
  parameter int unsigned POSITION_BITS = 14,
  parameter int unsigned SAMPLE_BITS   = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pvr_pkg::cfg_t            cfg_i,
  input  logic                     step_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic                     last_i,
  output logic                     ev_valid_o,
  output pvr_pkg::event_e          ev_o,
  output logic [POSITION_BITS-1:0] position_o,
  output logic [SAMPLE_BITS-1:0]   level_o,
  output logic                     series_done_o,
  output logic [POSITION_BITS-1:0] peak_count_o,
  output logic [SAMPLE_BITS-1:0]   global_max_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + pvr_pkg::RATIO_W;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  // Series state.
  logic [SAMPLE_BITS-1:0]   prev_q, prev_d;
  logic [SAMPLE_BITS-1:0]   pprev_q, pprev_d;
  logic [POSITION_BITS-1:0] idx_q, idx_d;
  logic                     seek_valley_q, seek_valley_d;
  logic [SAMPLE_BITS-1:0]   valley_q, valley_d;
  logic [SAMPLE_BITS-1:0]   pend_peak_q, pend_peak_d;
  logic [POSITION_BITS-1:0] peaks_q, peaks_d;
  logic [SAMPLE_BITS-1:0]   max_q, max_d;

  // Floor level brought to the sample width.
  logic [SAMPLE_BITS+pvr_pkg::CFG_DATA_W-1:0] floor_wide;
  logic [SAMPLE_BITS-1:0]                     floor_s;
  assign floor_wide = {{SAMPLE_BITS{1'b0}}, cfg_i.floor_level};
  assign floor_s    = floor_wide[SAMPLE_BITS-1:0];

  // Ratio tests: level times 256 against threshold times level.
  logic [PROD_W-1:0] valley_x256, cand_x256, ratio_cand, ratio_pend;
  assign valley_x256 = {valley_q, 8'd0};
  assign cand_x256   = {prev_q, 8'd0};
  assign ratio_cand  = PROD_W'(cfg_i.ratio_threshold) * PROD_W'(prev_q);
  assign ratio_pend  = PROD_W'(cfg_i.ratio_threshold) * PROD_W'(pend_peak_q);

  logic idx_zero, idx_ge2, peak_cand, valley_cand, peak_ok, cancel;
  assign idx_zero    = (idx_q == '0);
  assign idx_ge2     = (idx_q[POSITION_BITS-1:1] != '0);
  assign peak_cand   = !seek_valley_q && (prev_q > floor_s) &&
                       (prev_q >= sample_i) && (prev_q >= pprev_q);
  assign valley_cand = seek_valley_q && (prev_q <= sample_i) && (prev_q <= pprev_q);
  assign peak_ok     = (valley_x256 < ratio_cand);
  assign cancel      = (cand_x256 > ratio_pend);

  // Decision and next state for one sample.
  always_comb begin
    prev_d        = sample_i;
    pprev_d       = prev_q;
    idx_d         = (idx_q != POS_MAX) ? idx_q + POS_ONE : idx_q;
    seek_valley_d = seek_valley_q;
    valley_d      = valley_q;
    pend_peak_d   = pend_peak_q;
    peaks_d       = peaks_q;
    max_d         = (sample_i > max_q || idx_zero) ? sample_i : max_q;

    ev_valid_o    = 1'b0;
    ev_o          = pvr_pkg::EV_START_VALLEY;
    position_o    = idx_q - POS_ONE;
    level_o       = prev_q;
    series_done_o = 1'b0;

    if (idx_zero) begin
      valley_d      = sample_i;
      seek_valley_d = 1'b0;
      ev_valid_o    = 1'b1;
      ev_o          = pvr_pkg::EV_START_VALLEY;
      position_o    = '0;
      level_o       = sample_i;
      series_done_o = last_i;
    end else if (last_i) begin
      ev_valid_o    = 1'b1;
      ev_o          = (idx_ge2 && seek_valley_q) ? pvr_pkg::EV_END_VALLEY
                                                 : pvr_pkg::EV_END_NO_VALLEY;
      position_o    = idx_q;
      level_o       = sample_i;
      series_done_o = 1'b1;
    end else if (idx_ge2) begin
      if (peak_cand) begin
        if (peak_ok) begin
          seek_valley_d = 1'b1;
          pend_peak_d   = prev_q;
          if (peaks_q != POS_MAX) begin
            peaks_d = peaks_q + POS_ONE;
          end
          ev_valid_o = 1'b1;
          ev_o       = pvr_pkg::EV_PEAK;
        end
      end else if (valley_cand) begin
        ev_valid_o    = 1'b1;
        seek_valley_d = 1'b0;
        if (cancel) begin
          if (peaks_q != '0) begin
            peaks_d = peaks_q - POS_ONE;
          end
          ev_o = pvr_pkg::EV_PEAK_CANCEL;
        end else begin
          valley_d = prev_q;
          ev_o     = pvr_pkg::EV_VALLEY;
        end
      end
    end

    // Series totals go out only with the final word.
    peak_count_o = series_done_o ? peaks_q : '0;
    global_max_o = series_done_o ? max_d : '0;

    // The final sample returns the series state to its start.
    if (last_i) begin
      prev_d        = '0;
      pprev_d       = '0;
      idx_d         = '0;
      seek_valley_d = 1'b0;
      valley_d      = '0;
      pend_peak_d   = '0;
      peaks_d       = '0;
      max_d         = '0;
    end
  end

  // State register, updated once per processed sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q        <= '0;
      pprev_q       <= '0;
      idx_q         <= '0;
      seek_valley_q <= 1'b0;
      valley_q      <= '0;
      pend_peak_q   <= '0;
      peaks_q       <= '0;
      max_q         <= '0;
    end else if (step_i) begin
      prev_q        <= prev_d;
      pprev_q       <= pprev_d;
      idx_q         <= idx_d;
      seek_valley_q <= seek_valley_d;
      valley_q      <= valley_d;
      pend_peak_q   <= pend_peak_d;
      peaks_q       <= peaks_d;
      max_q         <= max_d;
    end
  end

endmodule

// ===== src/peak_valley_ratio_detector.sv =====
// Top level of the peak and valley detector with ratio hysteresis.
// The block takes one density sample per cycle. An accepted word is held in
// an input register, then the detection core decides on it and updates the
// series state, and any event word lands in the result register in the same
// cycle as that state update. Samples that cause no event produce no output
// word. The rate is one sample per clock, set by the state update of the
// core; it holds while the result side does not stall. The threshold and
// floor registers are written through the configuration port; the user must
// write them only while the block is idle, as the block does not enforce it.
module peak_valley_ratio_detector #(
  parameter int unsigned POSITION_BITS = 14,
  parameter int unsigned SAMPLE_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [pvr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pvr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Sample channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  input  logic                              last_in_series_i,
  // Event channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        event_res_o,
  output logic [POSITION_BITS-1:0]          position_o,
  output logic [SAMPLE_BITS-1:0]            level_o,
  output logic                              series_done_o,
  output logic [POSITION_BITS-1:0]          peak_count_o,
  output logic [SAMPLE_BITS-1:0]            global_max_o
);

  // Configuration registers.
  pvr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ratio_threshold <= pvr_pkg::RATIO_RESET;
      cfg_q.floor_level     <= pvr_pkg::FLOOR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pvr_pkg::CFG_RATIO_THRESHOLD: begin
          cfg_q.ratio_threshold <= cfg_wdata_i[pvr_pkg::RATIO_W-1:0];
        end
        pvr_pkg::CFG_FLOOR_LEVEL: begin
          cfg_q.floor_level <= cfg_wdata_i;
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Input register and handshake.
  logic                   in_vld_q, in_vld_d;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic                   last_q;
  logic                   in_accept, advance;

  logic out_vld_q, out_vld_d;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      smp_q  <= sample_i;
      last_q <= last_in_series_i;
    end
  end

  // Detection core.
  logic                     ev_valid;
  pvr_pkg::event_e          ev;
  logic [POSITION_BITS-1:0] ev_pos, ev_count;
  logic [SAMPLE_BITS-1:0]   ev_level, ev_max;
  logic                     ev_done;

  pvr_core #(
    .POSITION_BITS(POSITION_BITS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .step_i       (advance),
    .sample_i     (smp_q),
    .last_i       (last_q),
    .ev_valid_o   (ev_valid),
    .ev_o         (ev),
    .position_o   (ev_pos),
    .level_o      (ev_level),
    .series_done_o(ev_done),
    .peak_count_o (ev_count),
    .global_max_o (ev_max)
  );

  // Result register.
  pvr_pkg::event_e          ev_q;
  logic [POSITION_BITS-1:0] pos_q, count_q;
  logic [SAMPLE_BITS-1:0]   level_q, max_q;
  logic                     done_q;

  always_comb begin
    if (advance) begin
      out_vld_d = ev_valid;
    end else begin
      out_vld_d = out_vld_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ev_valid) begin
      ev_q    <= ev;
      pos_q   <= ev_pos;
      level_q <= ev_level;
      done_q  <= ev_done;
      count_q <= ev_count;
      max_q   <= ev_max;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign event_res_o   = ev_q;
  assign position_o    = pos_q;
  assign level_o       = level_q;
  assign series_done_o = done_q;
  assign peak_count_o  = count_q;
  assign global_max_o  = max_q;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the peak and valley ratio detector.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned POS_W        = 14;
  localparam int unsigned SMP_W        = 16;
  localparam int unsigned MAX_POS      = (1 << POS_W) - 1;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 400;

  // One sample word as offered on the input channel.
  typedef struct packed {
    logic [SMP_W-1:0] smp;
    logic             last;
  } sample_word_t;

  // One event word as reported on the output channel.
  typedef struct packed {
    pvr_pkg::event_e  ev;
    logic [POS_W-1:0] pos;
    logic [SMP_W-1:0] lvl;
    logic             done;
    logic [POS_W-1:0] peaks;
    logic [SMP_W-1:0] gmax;
  } event_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pvr_pkg::CFG_IDX_W-1:0] cfg_idx_i = pvr_pkg::CFG_RATIO_THRESHOLD;
  logic [pvr_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [SMP_W-1:0] sample_i = '0;
  logic last_in_series_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] event_res_o;
  logic [POS_W-1:0] position_o;
  logic [SMP_W-1:0] level_o;
  logic series_done_o;
  logic [POS_W-1:0] peak_count_o;
  logic [SMP_W-1:0] global_max_o;

  peak_valley_ratio_detector #(
    .POSITION_BITS(POS_W),
    .SAMPLE_BITS  (SMP_W)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .last_in_series_i(last_in_series_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_res_o     (event_res_o),
    .position_o      (position_o),
    .level_o         (level_o),
    .series_done_o   (series_done_o),
    .peak_count_o    (peak_count_o),
    .global_max_o    (global_max_o)
  );

  always #5 clk_i = ~clk_i;

  // Words waiting to be sent and events waiting to be seen.
  sample_word_t sample_q[$];
  event_word_t  event_q[$];

  // Levels of the directed series with two peaks and a valley between them.
  logic [SMP_W-1:0] dir_lvls [7] = '{16'd10, 16'd20, 16'd100, 16'd30, 16'd50, 16'd60,
                                     16'd40};

  // Shadow copy of the configuration registers.
  logic [pvr_pkg::RATIO_W-1:0] ratio_cfg = pvr_pkg::RATIO_RESET;
  logic [SMP_W-1:0]            floor_cfg = pvr_pkg::FLOOR_RESET;

  // Shadow copy of the series state.
  logic [SMP_W-1:0] prev_s = '0;
  logic [SMP_W-1:0] prev2_s = '0;
  logic [POS_W-1:0] smp_idx = '0;
  logic             seek_valley = 1'b0;
  logic [SMP_W-1:0] valley_lvl = '0;
  logic [SMP_W-1:0] peak_lvl = '0;
  logic [POS_W-1:0] peak_cnt = '0;
  logic [SMP_W-1:0] run_max = '0;

  // Traffic shaping knobs, set per phase.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;
  logic in_taken = 1'b0;

  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned events_checked = 0;
  int unsigned series_cnt = 0;
  int unsigned peaks_seen = 0;
  int unsigned cancels_seen = 0;
  int unsigned idle_cycles = 0;

  function automatic event_word_t make_event(pvr_pkg::event_e ev, logic [POS_W-1:0] pos,
                                             logic [SMP_W-1:0] lvl, logic done);
    event_word_t w;
    w.ev    = ev;
    w.pos   = pos;
    w.lvl   = lvl;
    w.done  = done;
    w.peaks = done ? peak_cnt : '0;
    w.gmax  = done ? run_max : '0;
    return w;
  endfunction

  // Advance the series state by one sample and queue the event it causes.
  function automatic void predict_event(logic [SMP_W-1:0] s, logic last);
    logic [SMP_W-1:0] c;
    logic [23:0] lhs;
    logic [23:0] rhs;
    c = prev_s;
    if (s > run_max || smp_idx == 0) run_max = s;
    if (smp_idx == 0) begin
      valley_lvl = s;
      seek_valley = 1'b0;
      event_q.push_back(make_event(pvr_pkg::EV_START_VALLEY, '0, s, last));
    end else if (last) begin
      if (smp_idx >= 2 && seek_valley) begin
        event_q.push_back(make_event(pvr_pkg::EV_END_VALLEY, smp_idx, s, 1'b1));
      end else begin
        event_q.push_back(make_event(pvr_pkg::EV_END_NO_VALLEY, smp_idx, s, 1'b1));
      end
    end else if (smp_idx >= 2) begin
      if (!seek_valley && c > floor_cfg && c >= s && c >= prev2_s) begin
        // Peak candidate: it must rise far enough above the last valley.
        lhs = {valley_lvl, 8'h00};
        rhs = 24'(ratio_cfg) * 24'(c);
        if (lhs < rhs) begin
          seek_valley = 1'b1;
          peak_lvl = c;
          if (peak_cnt < MAX_POS) peak_cnt = peak_cnt + 1'b1;
          event_q.push_back(make_event(pvr_pkg::EV_PEAK, smp_idx - 1'b1, c, 1'b0));
        end
      end else if (seek_valley && c <= s && c <= prev2_s) begin
        // Valley candidate: too shallow a dip cancels the pending peak.
        lhs = {c, 8'h00};
        rhs = 24'(ratio_cfg) * 24'(peak_lvl);
        if (lhs > rhs) begin
          if (peak_cnt > 0) peak_cnt = peak_cnt - 1'b1;
          event_q.push_back(make_event(pvr_pkg::EV_PEAK_CANCEL, smp_idx - 1'b1, c, 1'b0));
        end else begin
          valley_lvl = c;
          event_q.push_back(make_event(pvr_pkg::EV_VALLEY, smp_idx - 1'b1, c, 1'b0));
        end
        seek_valley = 1'b0;
      end
    end
    if (last) begin
      prev_s = '0;
      prev2_s = '0;
      smp_idx = '0;
      seek_valley = 1'b0;
      valley_lvl = '0;
      peak_lvl = '0;
      peak_cnt = '0;
      run_max = '0;
    end else begin
      prev2_s = prev_s;
      prev_s = s;
      if (smp_idx < MAX_POS) smp_idx = smp_idx + 1'b1;
    end
  endfunction

  function automatic void push_sample(logic [SMP_W-1:0] s, logic last);
    sample_word_t w;
    w.smp = s;
    w.last = last;
    sample_q.push_back(w);
    if (last) series_cnt++;
  endfunction

  // A series of len samples: a random walk of alternating runs, or noise
  // when scale is zero.
  function automatic void queue_series(int unsigned len, int unsigned scale);
    int unsigned lvl;
    int unsigned step;
    int unsigned run;
    logic up;
    lvl = $urandom_range(0, 65535);
    up = 1'($urandom_range(0, 1));
    run = $urandom_range(1, 4);
    for (int unsigned i = 0; i < len; i++) begin
      if (scale == 0) begin
        push_sample(SMP_W'($urandom), i == len - 1);
      end else begin
        push_sample(lvl[SMP_W-1:0], i == len - 1);
        step = $urandom_range(0, scale);
        if (up) lvl = (lvl + step > 65535) ? 65535 : lvl + step;
        else lvl = (lvl < step) ? 0 : lvl - step;
        run--;
        if (run == 0) begin
          up = ~up;
          run = $urandom_range(1, 4);
        end
      end
    end
  endfunction

  // Mostly shaped series of random length, with short and noisy ones mixed in.
  function automatic void load_random(int unsigned n);
    int unsigned added;
    int unsigned kind;
    int unsigned len;
    int unsigned scale;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: len = 1;
        1: len = 2;
        default: len = $urandom_range(3, 40);
      endcase
      case ($urandom_range(0, 3))
        0: scale = 3;
        1: scale = 300;
        2: scale = 6000;
        default: scale = 30000;
      endcase
      if (kind == 2) scale = 0;
      queue_series(len, scale);
      added += len;
    end
  endfunction

  // Wait until every word is sent and every event is seen, then let the
  // pipeline settle in case the last samples caused no event.
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid_i || event_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [pvr_pkg::CFG_IDX_W-1:0] idx,
                           logic [pvr_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    if (idx == pvr_pkg::CFG_RATIO_THRESHOLD) ratio_cfg = data[pvr_pkg::RATIO_W-1:0];
    else floor_cfg = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [pvr_pkg::RATIO_W-1:0] ratio, logic [SMP_W-1:0] floor_lvl);
    wait_drained();
    write_reg(pvr_pkg::CFG_RATIO_THRESHOLD, pvr_pkg::CFG_DATA_W'(ratio));
    write_reg(pvr_pkg::CFG_FLOOR_LEVEL, floor_lvl);
  endtask

  // Sample driver: hold a stalled word, otherwise offer the next one or idle.
  always @(negedge clk_i) begin
    if (in_valid_i && !in_taken) begin
      // Word still waiting for acceptance.
    end else if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid_i <= 1'b1;
      sample_i <= sample_q[0].smp;
      last_in_series_i <= sample_q[0].last;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Accepted sample words feed the predictor.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_event(sample_i, last_in_series_i);
      void'(sample_q.pop_front());
      samples_sent++;
    end
  end

  // Event side stall: random, or one long hold when requested.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Event monitor: compare each accepted event word with the oldest prediction.
  always @(posedge clk_i) begin
    event_word_t got;
    event_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.ev    = pvr_pkg::event_e'(event_res_o);
      got.pos   = position_o;
      got.lvl   = level_o;
      got.done  = series_done_o;
      got.peaks = peak_count_o;
      got.gmax  = global_max_o;
      events_checked++;
      if (got.ev == pvr_pkg::EV_PEAK) peaks_seen++;
      if (got.ev == pvr_pkg::EV_PEAK_CANCEL) cancels_seen++;
      if (event_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected event word ev=%0d pos=%0d lvl=%0d", $realtime,
                   event_res_o, position_o, level_o);
        end
      end else begin
        want = event_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: event mismatch", $realtime);
            $display("  expected ev=%0d pos=%0d lvl=%0d done=%0d peaks=%0d max=%0d",
                     want.ev, want.pos, want.lvl, want.done, want.peaks, want.gmax);
            $display("  actual   ev=%0d pos=%0d lvl=%0d done=%0d peaks=%0d max=%0d",
                     event_res_o, position_o, level_o, series_done_o, peak_count_o,
                     global_max_o);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved in %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed series under reset settings, no idling.
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'd0, 1'b0);
    push_sample(16'd0, 1'b1);
    foreach (dir_lvls[k]) begin
      push_sample(dir_lvls[k], 1'b0);
    end
    push_sample(16'd45, 1'b1);
    push_sample(16'd0, 1'b0);
    push_sample(16'd1000, 1'b0);
    push_sample(16'd950, 1'b0);
    push_sample(16'd990, 1'b0);
    push_sample(16'd0, 1'b1);
    push_sample(16'd0, 1'b0);
    push_sample(16'd7, 1'b0);
    push_sample(16'd0, 1'b0);
    push_sample(16'd0, 1'b1);

    // Highest ratio and lowest floor, sender idling.
    set_config(8'd255, 16'd0);
    send_idle_pct = 57;
    load_random(100);

    // Lowest ratio and highest floor, receiver stalling.
    set_config(8'd1, 16'hFFFF);
    send_idle_pct = 0;
    stall_pct = 57;
    load_random(80);

    // Zero ratio: no peak can pass.
    set_config(8'd0, 16'($urandom_range(0, 65535)));
    send_idle_pct = 26;
    stall_pct = 26;
    load_random(60);

    // Random settings with a long receiver hold while the sender keeps going.
    set_config(8'($urandom_range(1, 255)), 16'($urandom_range(0, 2000)));
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    load_random(120);

    // Reset settings; the sender pauses mid-phase until all events are in.
    set_config(pvr_pkg::RATIO_RESET, pvr_pkg::FLOOR_RESET);
    send_idle_pct = 26;
    stall_pct = 26;
    load_random(70);
    wait_drained();
    load_random(70);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d samples in %0d series over six register settings.",
             samples_sent, series_cnt);
    $display("Checked %0d events (%0d peaks, %0d cancelled), %0d mismatches.",
             events_checked, peaks_seen, cancels_seen, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
